FILE: rtl/vf_curve_start_time_lookup_top_assert.svh
// Assertion macros for the curve start-time lookup checker.
// Used by vfst_check.sv; no other dependencies.
`ifndef VF_CURVE_START_TIME_LOOKUP_TOP_ASSERT_SVH
`define VF_CURVE_START_TIME_LOOKUP_TOP_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define VFST_ASSERT(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define VFST_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/vfst_pkg.sv
// Shared types and constants for the curve start-time lookup.
// No dependencies; imported by every other .sv file in rtl.
`default_nettype none
package vfst_pkg;

  localparam int VW = 32;
  localparam int MW = 33;
  localparam int PW = 66;

  typedef logic signed [VW-1:0] q16_t;
  typedef logic signed [MW-1:0] diff_t;

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  localparam logic [1:0] CASE_FREE = 2'd0;
  localparam logic [1:0] CASE_VOLT = 2'd1;
  localparam logic [1:0] CASE_FREQ = 2'd2;

  localparam logic [1:0] REG_POINTS     = 2'd0;
  localparam logic [1:0] REG_FREQ_LIMIT = 2'd1;
  localparam logic [1:0] REG_VOLT_LIMIT = 2'd2;

  typedef struct packed {
    logic       operation;
    logic [3:0] point_index;
    q16_t       point_volt;
    q16_t       point_freq;
    q16_t       point_time;
    logic       enable;
    q16_t       freq_ref;
    q16_t       volt_ref;
  } in_item_t;

  typedef struct packed {
    q16_t       start_time;
    q16_t       freq_limit_out;
    q16_t       volt_limit_out;
    logic       updated;
    logic [1:0] case_taken;
  } out_item_t;

  typedef enum logic [1:0] {SEL_VF, SEL_TV, SEL_TF} sel_t;

  typedef enum logic [3:0] {
    DP_NONE, DP_LAST, DP_FIRST, DP_STEP, DP_MDSTART, DP_FLAT, DP_MDEND,
    DP_C0, DP_C1, DP_C2
  } dp_op_t;

  typedef struct packed {
    logic   accept;
    dp_op_t op;
    sel_t   sel;
    logic   out_load;
    logic   out_updated;
  } vfst_cmd_t;

  typedef struct packed {
    logic is_sample;
    logic rise;
    logic clamp;
    logic hit;
    logic dx_zero;
    logic md_done;
    logic case0;
    logic vge;
  } vfst_stat_t;

endpackage
`default_nettype wire

FILE: rtl/vfst_ifs.sv
// Valid/ready channel interfaces for request and result items.
// Depends on vfst_pkg.
`default_nettype none
interface vfst_req_if import vfst_pkg::*; ;
  logic     valid;
  logic     ready;
  in_item_t item;
  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

interface vfst_rsp_if import vfst_pkg::*; ;
  logic      valid;
  logic      ready;
  out_item_t item;
  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface
`default_nettype wire

FILE: rtl/vf_curve_start_time_lookup_top.sv
// Top level of the curve start-time lookup: controller plus datapath.
// Depends on vfst_pkg, vfst_ifs, vfst_ctrl, vfst_dp and vfst_muldiv.
//
// Usage:
//   req carries load and sample items; rsp carries one result item per
//   sample item and nothing for a load item. The user must write
//   points_in_use, freq_limit and volt_limit through wr_en/wr_index/wr_data
//   only while the block is idle; the block itself does not enforce this. A
//   load item is written into the point tables as it is taken. A sample item
//   without a rising enable returns the held values the cycle after it is
//   taken (updated = 0). A sample item with a rising enable runs one or two
//   table interpolations; each reads the last and the first end points,
//   scans the table segments up to the last point, then starts the shared
//   multiply/divide unit, waits for it and settles; a clamped reference
//   skips the scan and the divide, and a flat segment skips the divide. One
//   item is in work at a time. While a result waits on a stalled receiver,
//   no item is taken and a finished evaluation waits. Reset clears the
//   handshakes, the held results and the registers to their defaults
//   (points_in_use = 16); table contents are undefined until loaded. Reset
//   is synchronous and active high.
`default_nettype none
module vf_curve_start_time_lookup_top import vfst_pkg::*; #(
  parameter int MAX_POINTS = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr_en,
  input  logic [1:0]      wr_index,
  input  logic [VW-1:0]   wr_data,
  vfst_req_if.sink        req,
  vfst_rsp_if.source      rsp
);
  localparam int AW = $clog2(MAX_POINTS);

  vfst_cmd_t     cmd;
  vfst_stat_t    stat;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] nlast;

  vfst_ctrl #(.MAX_POINTS(MAX_POINTS)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .stat      (stat),
    .nlast     (nlast),
    .cmd       (cmd),
    .rd_addr   (rd_addr)
  );

  vfst_dp #(.MAX_POINTS(MAX_POINTS)) u_dp (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .req_item (req.item),
    .rsp_item (rsp.item),
    .cmd      (cmd),
    .rd_addr  (rd_addr),
    .stat     (stat),
    .nlast    (nlast)
  );
endmodule
`default_nettype wire

FILE: rtl/vfst_muldiv.sv
// Sequential unsigned multiply (33 steps) then restoring divide (66 steps).
// Depends on vfst_pkg; returns the low 32 quotient bits of a*b/d.
`default_nettype none
module vfst_muldiv import vfst_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [MW-1:0] a,
  input  logic [MW-1:0] b,
  input  logic [MW-1:0] d,
  output logic          done,
  output logic [VW-1:0] q
);
  localparam int CW = $clog2(PW);

  typedef enum logic [1:0] {M_IDLE, M_MUL, M_DIV} phase_t;

  phase_t        phase;
  logic [CW-1:0] cnt;
  logic [MW:0]   acc_hi;
  logic [MW-1:0] acc_lo;
  logic [MW-1:0] mcand;
  logic [MW-1:0] dsr;
  logic [PW-1:0] num;
  logic [MW-1:0] rem;
  logic [MW:0]   sum;
  logic [MW:0]   hi_next;
  logic [MW-1:0] lo_next;
  logic [MW:0]   shifted;
  logic          ge;

  always_comb begin
    sum     = acc_hi + (acc_lo[0] ? {1'b0, mcand} : '0);
    hi_next = {1'b0, sum[MW:1]};
    lo_next = {sum[0], acc_lo[MW-1:1]};
    shifted = {rem, num[PW-1]};
    ge      = shifted >= {1'b0, dsr};
  end

  always_ff @(posedge clk) begin
    done <= 1'b0;
    case (phase)
      M_IDLE: begin
        if (start) begin
          acc_hi <= '0;
          acc_lo <= b;
          mcand  <= a;
          dsr    <= d;
          cnt    <= '0;
          phase  <= M_MUL;
        end
      end
      M_MUL: begin
        acc_hi <= hi_next;
        acc_lo <= lo_next;
        if (cnt == CW'(MW - 1)) begin
          num   <= {hi_next[MW-1:0], lo_next};
          rem   <= '0;
          cnt   <= '0;
          phase <= M_DIV;
        end else begin
          cnt <= cnt + CW'(1);
        end
      end
      M_DIV: begin
        rem <= ge ? MW'(shifted - {1'b0, dsr}) : shifted[MW-1:0];
        num <= {num[PW-2:0], ge};
        if (cnt == CW'(PW - 1)) begin
          done  <= 1'b1;
          phase <= M_IDLE;
        end else begin
          cnt <= cnt + CW'(1);
        end
      end
      default: phase <= M_IDLE;
    endcase
    if (rst) begin
      phase <= M_IDLE;
      done  <= 1'b0;
    end
  end

  assign q = num[VW-1:0];
endmodule
`default_nettype wire

FILE: rtl/vfst_dp.sv
// Datapath: point tables, config and held registers, segment scan and result.
// Depends on vfst_pkg and vfst_muldiv; driven by vfst_ctrl commands.
`default_nettype none
module vfst_dp import vfst_pkg::*; #(
  parameter int MAX_POINTS = 16,
  localparam int AW = $clog2(MAX_POINTS)
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr_en,
  input  logic [1:0]      wr_index,
  input  logic [VW-1:0]   wr_data,
  input  in_item_t        req_item,
  output out_item_t       rsp_item,
  input  vfst_cmd_t       cmd,
  input  logic [AW-1:0]   rd_addr,
  output vfst_stat_t      stat,
  output logic [AW-1:0]   nlast
);
  q16_t volt_mem [MAX_POINTS];
  q16_t freq_mem [MAX_POINTS];
  q16_t time_mem [MAX_POINTS];
  q16_t rd_v, rd_f, rd_t;

  logic [4:0] pts;
  q16_t       flim, vlim;
  logic       prev_en;
  q16_t       fref_l, vref_l;
  q16_t       held_st, held_fl, held_vl;
  logic [1:0] held_case;

  q16_t  xl, yl, prev_x, prev_y, ya, res, v0, f0;
  diff_t da, dx, dy;

  q16_t          x_cur, y_cur, p;
  logic [31:0]   wa_full, nsel, nlast_w;
  logic [AW-1:0] wa;
  logic          desc, lo_hit, hi_hit, neg;
  logic          md_done;
  logic [VW-1:0] md_q;
  logic [MW-1:0] ua, ub, uc;

  always_comb begin
    wa_full = '0;
    for (int k = 0; k < 16; k++) begin
      if (req_item.point_index == 4'(k)) wa_full = 32'(k % MAX_POINTS);
    end
    wa      = wa_full[AW-1:0];
    if (pts < 5'd2) nsel = 32'd2;
    else if (32'(pts) > MAX_POINTS) nsel = 32'(MAX_POINTS);
    else nsel = 32'(pts);
    nlast_w = nsel - 32'd1;
    nlast   = nlast_w[AW-1:0];
    case (cmd.sel)
      SEL_VF:  begin y_cur = rd_v; x_cur = rd_f; p = fref_l; end
      SEL_TV:  begin y_cur = rd_t; x_cur = rd_v; p = vref_l; end
      default: begin y_cur = rd_t; x_cur = rd_f; p = fref_l; end
    endcase
    desc   = x_cur > xl;
    lo_hit = desc ? (p >= x_cur) : (p <= x_cur);
    hi_hit = desc ? (p <= xl) : (p >= xl);
    neg    = da[MW-1] ^ dy[MW-1] ^ dx[MW-1];
    ua     = da[MW-1] ? MW'(-da) : MW'(da);
    ub     = dy[MW-1] ? MW'(-dy) : MW'(dy);
    uc     = dx[MW-1] ? MW'(-dx) : MW'(dx);
    stat.is_sample = req_item.operation == OP_SAMPLE;
    stat.rise      = req_item.enable && !prev_en;
    stat.clamp     = lo_hit || hi_hit;
    stat.hit       = (prev_x < p && p <= x_cur) || (x_cur < p && p <= prev_x);
    stat.dx_zero   = dx == '0;
    stat.md_done   = md_done;
    stat.case0     = vref_l >= v0 && fref_l >= f0;
    stat.vge       = vref_l >= res;
  end

  vfst_muldiv u_muldiv (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.op == DP_MDSTART),
    .a     (ua),
    .b     (ub),
    .d     (uc),
    .done  (md_done),
    .q     (md_q)
  );

  always_ff @(posedge clk) begin
    if (cmd.accept && req_item.operation == OP_LOAD) begin
      volt_mem[wa] <= req_item.point_volt;
      freq_mem[wa] <= req_item.point_freq;
      time_mem[wa] <= req_item.point_time;
    end
    rd_v <= volt_mem[rd_addr];
    rd_f <= freq_mem[rd_addr];
    rd_t <= time_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && req_item.operation == OP_SAMPLE) begin
      fref_l <= req_item.freq_ref;
      vref_l <= req_item.volt_ref;
    end
    case (cmd.op)
      DP_LAST: begin
        xl <= x_cur;
        yl <= y_cur;
      end
      DP_FIRST: begin
        prev_x <= x_cur;
        prev_y <= y_cur;
        res    <= lo_hit ? y_cur : yl;
        if (cmd.sel == SEL_VF) begin
          v0 <= rd_v;
          f0 <= rd_f;
        end
      end
      DP_STEP: begin
        prev_x <= x_cur;
        prev_y <= y_cur;
        ya     <= prev_y;
        da     <= {p[VW-1], p} - {prev_x[VW-1], prev_x};
        dx     <= {x_cur[VW-1], x_cur} - {prev_x[VW-1], prev_x};
        dy     <= {y_cur[VW-1], y_cur} - {prev_y[VW-1], prev_y};
      end
      DP_FLAT:  res <= ya;
      DP_MDEND: res <= neg ? ya - q16_t'(md_q) : ya + q16_t'(md_q);
      default: ;
    endcase
    if (cmd.out_load) begin
      rsp_item.start_time     <= held_st;
      rsp_item.freq_limit_out <= held_fl;
      rsp_item.volt_limit_out <= held_vl;
      rsp_item.updated        <= cmd.out_updated;
      rsp_item.case_taken     <= held_case;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pts       <= 5'd16;
      flim      <= '0;
      vlim      <= '0;
      prev_en   <= 1'b0;
      held_st   <= '0;
      held_fl   <= '0;
      held_vl   <= '0;
      held_case <= CASE_FREE;
    end else begin
      if (wr_en) begin
        case (wr_index)
          REG_POINTS:     pts  <= wr_data[4:0];
          REG_FREQ_LIMIT: flim <= wr_data;
          REG_VOLT_LIMIT: vlim <= wr_data;
          default: ;
        endcase
      end
      if (cmd.accept && req_item.operation == OP_SAMPLE) prev_en <= req_item.enable;
      case (cmd.op)
        DP_C0: begin
          held_st   <= '0;
          held_fl   <= flim;
          held_vl   <= vlim;
          held_case <= CASE_FREE;
        end
        DP_C1: begin
          held_st   <= res;
          held_fl   <= fref_l;
          held_vl   <= vlim;
          held_case <= CASE_VOLT;
        end
        DP_C2: begin
          held_st   <= res;
          held_fl   <= flim;
          held_vl   <= vref_l;
          held_case <= CASE_FREQ;
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

FILE: rtl/vfst_ctrl.sv
// Controller: sequences table scans, arithmetic and result hand-off.
// Depends on vfst_pkg; drives vfst_dp through command and status structs.
`default_nettype none
module vfst_ctrl import vfst_pkg::*; #(
  parameter int MAX_POINTS = 16,
  localparam int AW = $clog2(MAX_POINTS)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  input  vfst_stat_t    stat,
  input  logic [AW-1:0] nlast,
  output vfst_cmd_t     cmd,
  output logic [AW-1:0] rd_addr
);
  typedef enum logic [3:0] {
    S_IDLE, S_LAST, S_LATL, S_FIRST, S_SCAN, S_MDGO, S_MDWAIT, S_RES, S_OUT
  } state_t;

  state_t        state, state_next;
  sel_t          sel, sel_next;
  logic [AW-1:0] cnt, cnt_next;
  logic          out_valid, out_valid_next;
  logic          out_free;

  always_comb begin
    state_next     = state;
    sel_next       = sel;
    cnt_next       = cnt;
    out_free       = !out_valid || rsp_ready;
    out_valid_next = out_valid && !rsp_ready;
    req_ready      = state == S_IDLE && out_free;
    rd_addr        = '0;
    cmd            = '0;
    cmd.op         = DP_NONE;
    cmd.sel        = sel;
    case (state)
      S_IDLE: begin
        if (req_valid && req_ready) begin
          cmd.accept = 1'b1;
          if (stat.is_sample) begin
            if (stat.rise) begin
              sel_next   = SEL_VF;
              state_next = S_LAST;
            end else begin
              cmd.out_load   = 1'b1;
              out_valid_next = 1'b1;
            end
          end
        end
      end
      S_LAST: begin
        rd_addr    = nlast;
        state_next = S_LATL;
      end
      S_LATL: begin
        cmd.op     = DP_LAST;
        state_next = S_FIRST;
      end
      S_FIRST: begin
        cmd.op     = DP_FIRST;
        rd_addr    = AW'(1);
        cnt_next   = AW'(1);
        state_next = stat.clamp ? S_RES : S_SCAN;
      end
      S_SCAN: begin
        cmd.op  = DP_STEP;
        rd_addr = cnt + AW'(1);
        if (stat.hit || cnt == nlast) state_next = S_MDGO;
        else cnt_next = cnt + AW'(1);
      end
      S_MDGO: begin
        if (stat.dx_zero) begin
          cmd.op     = DP_FLAT;
          state_next = S_RES;
        end else begin
          cmd.op     = DP_MDSTART;
          state_next = S_MDWAIT;
        end
      end
      S_MDWAIT: begin
        if (stat.md_done) begin
          cmd.op     = DP_MDEND;
          state_next = S_RES;
        end
      end
      S_RES: begin
        case (sel)
          SEL_VF: begin
            if (stat.case0) begin
              cmd.op     = DP_C0;
              state_next = S_OUT;
            end else begin
              sel_next   = stat.vge ? SEL_TV : SEL_TF;
              state_next = S_LAST;
            end
          end
          SEL_TV: begin
            cmd.op     = DP_C1;
            state_next = S_OUT;
          end
          default: begin
            cmd.op     = DP_C2;
            state_next = S_OUT;
          end
        endcase
      end
      S_OUT: begin
        if (out_free) begin
          cmd.out_load    = 1'b1;
          cmd.out_updated = 1'b1;
          out_valid_next  = 1'b1;
          state_next      = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      sel       <= SEL_VF;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      sel       <= sel_next;
      cnt       <= cnt_next;
      out_valid <= out_valid_next;
    end
  end

  assign rsp_valid = out_valid;
endmodule
`default_nettype wire

FILE: rtl/vfst_check.sv
// Port-level checker for the curve start-time lookup, bound to the top level.
// Depends on vfst_pkg and vf_curve_start_time_lookup_top_assert.svh.
`default_nettype none
`include "vf_curve_start_time_lookup_top_assert.svh"
module vfst_check import vfst_pkg::*; (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_ready,
  input logic          req_op,
  input logic          rsp_valid,
  input logic          rsp_ready,
  input logic [1:0]    rsp_case,
  input logic [VW-1:0] rsp_start
);
  `VFST_ASSERT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready |=> rsp_valid, "result item dropped")
  `VFST_ASSERT_ALWAYS(a_rst_empty, clk, rst |=> !rsp_valid, "result item after reset")
  `VFST_ASSERT(a_load_silent, clk, rst, req_valid && req_ready && req_op == OP_LOAD && !rsp_valid |=> !rsp_valid, "load item made a result")
  `VFST_ASSERT(a_free_zero, clk, rst, rsp_valid && rsp_case == CASE_FREE |-> rsp_start == '0, "start time not zero in free case")
endmodule

bind vf_curve_start_time_lookup_top vfst_check u_check (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .req_op    (req.item.operation),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .rsp_case  (rsp.item.case_taken),
  .rsp_start (rsp.item.start_time)
);
`default_nettype wire
